// ===== hdl/omni_wheel_drive_frame_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// Omni wheel drive frame encoder: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_DRIVE_FRAME_ENCODER_MACROS_SVH
`define OMNI_WHEEL_DRIVE_FRAME_ENCODER_MACROS_SVH

// consequence holds in the same cycle as the trigger
`define OWDE_ASSERT_SAME(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// consequence holds in the cycle after the trigger
`define OWDE_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/owde_pkg.sv =====
// ----------------------------------------------------------------------------
// Omni wheel drive frame encoder: package
// Types, constants and register codes shared by the encoder modules.
// ----------------------------------------------------------------------------
package owde_pkg;

    localparam int NUM_WHEELS  = 4;
    localparam int LANE_DEPTH  = 8;

    // frame layout
    localparam logic [7:0] FRAME_HEAD = 8'hFF;
    localparam logic [7:0] FRAME_TAIL = 8'hAA;

    typedef logic [3:0] frame_idx_t;
    localparam frame_idx_t FRAME_IDX_HEAD  = 4'd0;
    localparam frame_idx_t FRAME_IDX_CMD   = 4'd1;
    localparam frame_idx_t FRAME_IDX_WORD0 = 4'd2;
    localparam frame_idx_t FRAME_IDX_TAIL  = 4'd10;

    // commands in flight, counted from acceptance until their frame ends
    typedef logic [1:0] inflight_t;
    localparam inflight_t MAX_INFLIGHT = 2'd2;

    // configuration register codes
    typedef enum logic [2:0] {
        REG_WHEEL0_DIR   = 3'd0,
        REG_WHEEL1_DIR   = 3'd1,
        REG_WHEEL2_DIR   = 3'd2,
        REG_WHEEL3_DIR   = 3'd3,
        REG_BASE_RADIUS  = 3'd4,
        REG_INV_RADIUS   = 3'd5
    } cfg_index_t;

    localparam logic [19:0] BASE_RADIUS_RESET = 20'd80000;
    localparam logic [31:0] INV_RADIUS_RESET  = 32'd2340571;

    // wheel arithmetic constants
    localparam logic signed [42:0] MM_TO_UM     = 43'sd1000;
    localparam logic signed [42:0] TRUNC_BIAS   = 43'sd16383;
    // rad values at or above this many micro-units saturate
    localparam logic [53:0]        SAT_LIMIT    = 54'd32769000000;
    // divide by 15625 as multiply by reciprocal and shift
    localparam int                 RECIP_SHIFT  = 43;
    localparam logic [29:0]        RECIP_15625  = 30'((64'd1 << RECIP_SHIFT) / 64'd15625 + 64'd1);
    localparam logic [15:0]        WORD_SCALE   = 16'd100;
    localparam logic [15:0]        RAD_POS_MAX  = 16'd32767;
    localparam logic [15:0]        RAD_NEG_MAG  = 16'd32768;

    // one computed frame handed to the framer
    typedef struct packed {
        logic                              op;
        logic [NUM_WHEELS-1:0][15:0]       words;
    } frame_item_t;

endpackage

// ===== hdl/omni_wheel_drive_frame_encoder.sv =====
// ----------------------------------------------------------------------------
// Omni wheel drive frame encoder: top level
// Four-wheel omni inverse kinematics feeding an 11-byte motor command frame.
// ----------------------------------------------------------------------------
//  channel   | handshake                 | payload
//  ----------+---------------------------+----------------------------------
//  command   | start, busy               | operation, vel_x, vel_y, vel_turn
//  config    | cfg_valid, cfg_ready      | cfg_index, cfg_data
//  frame     | frame_strobe              | frame_byte, last
//
//  A command passes an eight-stage wheel pipeline (four lanes in parallel),
//  then its frame goes out one byte per cycle.
//  The byte serializer sets the sustained command rate.
//  Up to two commands are in flight; busy is high while two are held.
//  cfg_ready is always high. Reset clears the registers to their defaults.
//  The frame receiver must take every byte as it comes; the block has no output stall.
// ----------------------------------------------------------------------------
`include "omni_wheel_drive_frame_encoder_macros.svh"

module omni_wheel_drive_frame_encoder
    import owde_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] vel_turn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               frame_strobe,
    output logic [7:0]         frame_byte,
    output logic               last
);

    logic [NUM_WHEELS-1:0][31:0] dir_reg;
    logic [19:0]                 base_radius_reg;
    logic [31:0]                 inv_radius_reg;

    logic [LANE_DEPTH-1:0]       valid_pipe_reg, valid_pipe_next;
    logic [LANE_DEPTH-1:0]       op_pipe_reg;
    inflight_t                   count_reg, count_next;

    logic                        accept;
    logic                        frame_done;
    logic [NUM_WHEELS-1:0][15:0] lane_word;
    frame_item_t                 item;

    assign cfg_ready  = 1'b1;
    assign busy       = (count_reg == MAX_INFLIGHT);
    assign accept     = start && !busy;
    assign frame_done = frame_strobe && last;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg         <= '0;
            base_radius_reg <= BASE_RADIUS_RESET;
            inv_radius_reg  <= INV_RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                REG_WHEEL0_DIR:  dir_reg[0]      <= cfg_data;
                REG_WHEEL1_DIR:  dir_reg[1]      <= cfg_data;
                REG_WHEEL2_DIR:  dir_reg[2]      <= cfg_data;
                REG_WHEEL3_DIR:  dir_reg[3]      <= cfg_data;
                REG_BASE_RADIUS: base_radius_reg <= cfg_data[19:0];
                REG_INV_RADIUS:  inv_radius_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // in-flight command count and valid pipeline
    always_comb
    begin
        count_next      = count_reg + inflight_t'(accept) - inflight_t'(frame_done);
        valid_pipe_next = {valid_pipe_reg[LANE_DEPTH-2:0], accept};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            valid_pipe_reg <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            valid_pipe_reg <= valid_pipe_next;
        end
    end

    // command bit travels beside the lanes
    always_ff @(posedge clk)
    begin
        op_pipe_reg <= {op_pipe_reg[LANE_DEPTH-2:0], operation};
    end

    // one arithmetic lane per wheel
    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_lane
        owde_lane u_lane (
            .clk              (clk),
            .dir_word         (dir_reg[w]),
            .base_radius_um   (base_radius_reg),
            .inv_wheel_radius (inv_radius_reg),
            .vel_x            (vel_x),
            .vel_y            (vel_y),
            .vel_turn         (vel_turn),
            .word             (lane_word[w])
        );
        // free command sends zero words
        assign item.words[w] = op_pipe_reg[LANE_DEPTH-1] ? lane_word[w] : 16'd0;
    end

    assign item.op = op_pipe_reg[LANE_DEPTH-1];

    owde_framer u_framer (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (valid_pipe_reg[LANE_DEPTH-1]),
        .item         (item),
        .frame_strobe (frame_strobe),
        .frame_byte   (frame_byte),
        .last         (last)
    );

    // a finished frame or a command leaving the lanes always belongs to a counted command
    `OWDE_ASSERT_SAME(a_done_counted, frame_done || valid_pipe_reg[LANE_DEPTH-1], count_reg != 2'd0, "frame activity with no command in flight")
    // an accepted command without a frame ending raises the count
    `OWDE_ASSERT_NEXT(a_count_up, accept && !frame_done, count_reg == $past(count_reg) + 2'd1, "in-flight count missed an accepted command")

endmodule

// ===== hdl/owde_lane.sv =====
// ----------------------------------------------------------------------------
// Omni wheel drive frame encoder: wheel lane
// Eight-stage pipeline that turns a body velocity into one wheel word.
// ----------------------------------------------------------------------------
module owde_lane
    import owde_pkg::*;
(
    input  logic               clk,
    input  logic [31:0]        dir_word,
    input  logic [19:0]        base_radius_um,
    input  logic [31:0]        inv_wheel_radius,
    input  logic signed [15:0] vel_x,
    input  logic signed [15:0] vel_y,
    input  logic signed [15:0] vel_turn,
    output logic [15:0]        word
);

    logic signed [15:0] dir_sin;
    logic signed [15:0] dir_cos;

    logic signed [31:0] p_sin_reg, p_sin_next;
    logic signed [31:0] p_cos_reg, p_cos_next;
    logic signed [36:0] rot1_reg, rot1_next;
    logic signed [42:0] dk_reg, dk_next;
    logic signed [36:0] rot2_reg;
    logic signed [28:0] t_reg, t_next;
    logic signed [36:0] rot3_reg;
    logic [36:0]        mag_reg, mag_next;
    logic               neg4_reg, neg4_next;
    logic [52:0]        phi_reg, phi_next;
    logic [52:0]        plo_reg, plo_next;
    logic               neg5_reg;
    logic [28:0]        x_reg, x_next;
    logic               sat6_reg, sat6_next;
    logic               neg6_reg;
    logic [15:0]        q_reg, q_next;
    logic               sat7_reg;
    logic               neg7_reg;
    logic [15:0]        word_reg, word_next;

    logic signed [32:0] diff;
    logic signed [42:0] biased;
    logic signed [37:0] lin;
    logic [53:0]        sum;
    logic [58:0]        recip_prod;
    logic [15:0]        rad;

    assign dir_sin = dir_word[31:16];
    assign dir_cos = dir_word[15:0];

    // stage 1: direction products and rotation term
    always_comb
    begin
        p_sin_next = 32'(vel_x) * 32'(dir_sin);
        p_cos_next = 32'(vel_y) * 32'(dir_cos);
        rot1_next  = $signed({17'd0, base_radius_um}) * 37'(vel_turn);
    end

    // stage 2: direction speed in um/s scaled by 2^14
    always_comb
    begin
        diff    = 33'(p_cos_reg) - 33'(p_sin_reg);
        dk_next = 43'(diff) * MM_TO_UM;
    end

    // stage 3: drop the 2^14 scale, rounding toward zero
    always_comb
    begin
        biased = dk_reg + (dk_reg[42] ? TRUNC_BIAS : 43'sd0);
        t_next = biased[42:14];
    end

    // stage 4: wheel linear speed as sign and magnitude
    always_comb
    begin
        lin       = 38'(t_reg) + 38'(rot3_reg);
        neg4_next = lin[37];
        mag_next  = lin[37] ? 37'(-lin) : 37'(lin);
    end

    // stage 5: scale by reciprocal wheel radius, split in halves
    always_comb
    begin
        phi_next = 53'(mag_reg) * 53'(inv_wheel_radius[31:16]);
        plo_next = 53'(mag_reg) * 53'(inv_wheel_radius[15:0]);
    end

    // stage 6: combine halves, catch saturation, pre-divide by 64
    always_comb
    begin
        sum       = 54'(phi_reg) + 54'(plo_reg[52:16]);
        sat6_next = (sum >= SAT_LIMIT);
        x_next    = sum[34:6];
    end

    // stage 7: divide by 15625 by reciprocal multiply
    always_comb
    begin
        recip_prod = 59'(x_reg) * 59'(RECIP_15625);
        q_next     = recip_prod[58:RECIP_SHIFT];
    end

    // stage 8: clamp to int16 and scale by 100
    always_comb
    begin
        if (neg7_reg)
        begin
            rad = (sat7_reg || (q_reg > RAD_NEG_MAG)) ? RAD_NEG_MAG : 16'(-q_reg);
        end
        else
        begin
            rad = (sat7_reg || (q_reg > RAD_POS_MAX)) ? RAD_POS_MAX : q_reg;
        end
        word_next = 16'(rad * WORD_SCALE);
    end

    // pipeline registers, payload only
    always_ff @(posedge clk)
    begin
        p_sin_reg <= p_sin_next;
        p_cos_reg <= p_cos_next;
        rot1_reg  <= rot1_next;
        dk_reg    <= dk_next;
        rot2_reg  <= rot1_reg;
        t_reg     <= t_next;
        rot3_reg  <= rot2_reg;
        mag_reg   <= mag_next;
        neg4_reg  <= neg4_next;
        phi_reg   <= phi_next;
        plo_reg   <= plo_next;
        neg5_reg  <= neg4_reg;
        x_reg     <= x_next;
        sat6_reg  <= sat6_next;
        neg6_reg  <= neg5_reg;
        q_reg     <= q_next;
        sat7_reg  <= sat6_reg;
        neg7_reg  <= neg6_reg;
        word_reg  <= word_next;
    end

    assign word = word_reg;

endmodule

// ===== hdl/owde_framer.sv =====
// ----------------------------------------------------------------------------
// Omni wheel drive frame encoder: framer
// Serializes computed wheel words into 11-byte frames, with one waiting slot.
// ----------------------------------------------------------------------------
`include "omni_wheel_drive_frame_encoder_macros.svh"

module owde_framer
    import owde_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  frame_item_t item,
    output logic        frame_strobe,
    output logic [7:0]  frame_byte,
    output logic        last
);

    logic        active_reg, active_next;
    frame_idx_t  idx_reg, idx_next;
    frame_item_t cur_reg, cur_next;
    logic        pend_valid_reg, pend_valid_next;
    frame_item_t pend_reg, pend_next;

    logic        finish;
    logic        free_slot;
    frame_idx_t  byte_sel;
    logic [15:0] sel_word;

    assign finish    = active_reg && (idx_reg == FRAME_IDX_TAIL);
    assign free_slot = !active_reg || finish;

    // next frame selection and byte counter
    always_comb
    begin
        active_next     = active_reg;
        idx_next        = idx_reg;
        cur_next        = cur_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (free_slot)
        begin
            idx_next = FRAME_IDX_HEAD;
            if (pend_valid_reg)
            begin
                active_next     = 1'b1;
                cur_next        = pend_reg;
                pend_valid_next = item_valid;
                pend_next       = item;
            end
            else if (item_valid)
            begin
                active_next = 1'b1;
                cur_next    = item;
            end
            else
            begin
                active_next = 1'b0;
            end
        end
        else
        begin
            idx_next = idx_reg + 4'd1;
            if (item_valid)
            begin
                pend_valid_next = 1'b1;
                pend_next       = item;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            idx_reg        <= FRAME_IDX_HEAD;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // frame payload
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        pend_reg <= pend_next;
    end

    // byte mux over the frame layout
    always_comb
    begin
        byte_sel = idx_reg - FRAME_IDX_WORD0;
        sel_word = cur_reg.words[byte_sel[2:1]];
        case (idx_reg)
            FRAME_IDX_HEAD: frame_byte = FRAME_HEAD;
            FRAME_IDX_CMD:  frame_byte = {7'd0, cur_reg.op};
            FRAME_IDX_TAIL: frame_byte = FRAME_TAIL;
            default:        frame_byte = byte_sel[0] ? sel_word[7:0] : sel_word[15:8];
        endcase
    end

    assign frame_strobe = active_reg;
    assign last         = finish;

    // the waiting slot never overflows
    `OWDE_ASSERT_SAME(a_pend_no_overflow, item_valid && !free_slot, !pend_valid_reg, "framer waiting slot overrun")
    // a frame in progress runs its bytes without gaps
    `OWDE_ASSERT_NEXT(a_frame_contiguous, active_reg && !finish, active_reg && (idx_reg == $past(idx_reg) + 4'd1), "frame byte sequence broken")

endmodule
